// ===== hw/rtl/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values, sequencer phases and helper functions.
// Used by every module of the stream hasher.
package sha256_pkg;

    typedef enum logic [3:0] {
        P_IDLE, P_BYTE, P_BYTE_WR, P_PADW, P_SCH_A, P_SCH_B, P_SCH_C, P_SCH_D,
        P_ROUND, P_ADD_RD, P_ADD_WR, P_LEN, P_EMIT_RD, P_EMIT
    } t_phase;

    localparam logic [31:0] K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_WORD = 32'h80000000;
    localparam logic [31:0] PAD_BYTE = 32'h00000080;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round operands travel as a group from the control to the round unit
    typedef struct packed {
        logic        load;   // restart working variables from the hash words
        logic        step;   // run one round
        logic [31:0] kw;     // K[r] + W[r]
    } t_round_ctl;

endpackage

// ===== hw/rtl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: byte packing, schedule memory, sequencer,
// hash-word memory and digest output. Depends on sha256_pkg and sha256_round.
//
// Bytes enter one per transaction and are packed big-endian into a 16-word block
// memory with a read-modify-write on each byte. A byte that completes a 64-byte block
// starts a compression: the message schedule is expanded in place in the same memory,
// one word read per cycle, and the rounds run one after another on a shared round
// unit. Rounds 0 to 15 each read, latch and run the round, and rounds 16 to 63 each
// take four schedule reads, the write-back and the round; the result is then added
// into the hash-word memory. Other bytes pass through P_BYTE and P_BYTE_WR before
// ready returns. On a last transaction the padding is written one word per cycle
// (up to 16) and the length into words 14 and 15, one or two final blocks are
// compressed, and eight digest words are sent out on the master side, each read
// and then held until taken; the hash words then return to their initial values.
// No item is taken while a block is compressing or the digest is draining. There is
// no clearing pass.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    // Block memory: 16 words, one port read, one write, registered read data
    logic [31:0] r_blk [16];
    logic [31:0] r_blk_rd;
    logic [3:0]  n_blk_ra;
    logic        n_blk_we;
    logic [3:0]  n_blk_wa;
    logic [31:0] n_blk_wd;

    // Hash-word memory: 8 words
    logic [31:0] r_hw [8];
    logic [31:0] r_hw_rd;
    logic [2:0]  n_hw_ra;
    logic        n_hw_we;
    logic [2:0]  n_hw_wa;
    logic [31:0] n_hw_wd;
    logic [7:0]  r_hw_valid;   // cleared entry reads as initial value

    t_phase      r_ph, n_ph;
    logic [60:0] r_cnt, n_cnt;
    logic [6:0]  r_rnd, n_rnd;
    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_acc, n_acc;     // schedule partial sum
    logic [31:0] r_w, n_w;         // word for this round
    logic [7:0]  r_byte;
    logic        r_last, r_padding, n_padding;
    logic        r_second, n_second; // a second padded block follows
    logic [31:0] r_out;
    logic [2:0]  r_oidx;
    logic        r_ovalid, n_ovalid;
    logic [255:0] w_vars;
    t_round_ctl  w_rctl;
    logic [255:0] w_hash_flat;
    logic [5:0]  w_pos;
    logic [31:0] w_hval;

    assign w_pos  = r_cnt[5:0];
    assign w_hval = r_hw_valid[n_hw_ra] ? r_hw[n_hw_ra] : H_INIT[n_hw_ra];

    always_comb begin
        for (int i = 0; i < 8; i++)
            w_hash_flat[255 - 32*i -: 32] = r_hw_valid[i] ? r_hw[i] : H_INIT[i];
    end

    sha256_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (w_rctl),
        .i_hash (w_hash_flat),
        .o_vars (w_vars)
    );

    always_ff @(posedge i_clk) begin
        if (n_blk_we) r_blk[n_blk_wa] <= n_blk_wd;
        r_blk_rd <= r_blk[n_blk_ra];
        if (n_hw_we) r_hw[n_hw_wa] <= n_hw_wd;
        r_hw_rd <= w_hval;
    end

    assign s_axis_tready = (r_ph == P_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_oidx, r_out};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    // Next phase and datapath control
    always_comb begin
        n_ph = r_ph; n_cnt = r_cnt; n_rnd = r_rnd; n_idx = r_idx;
        n_acc = r_acc; n_w = r_w; n_padding = r_padding; n_second = r_second;
        n_ovalid = r_ovalid;
        n_blk_ra = r_idx; n_blk_we = 1'b0; n_blk_wa = r_idx; n_blk_wd = '0;
        n_hw_ra = r_idx[2:0]; n_hw_we = 1'b0; n_hw_wa = r_idx[2:0]; n_hw_wd = '0;
        w_rctl = '{load: 1'b0, step: 1'b0, kw: K_ROUND[r_rnd[5:0]] + r_w};
        unique case (r_ph)
            P_IDLE: begin
                n_blk_ra = w_pos[5:2];
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) n_ph = P_BYTE;
                    else if (s_axis_tlast) n_ph = P_PADW;
                    n_idx = w_pos[5:2];
                    n_padding = 1'b0;
                end
            end
            P_BYTE: begin
                // merge byte into the word read last cycle
                n_blk_we = 1'b1;
                n_blk_wa = w_pos[5:2];
                unique case (w_pos[1:0])
                    2'd0: n_blk_wd = {r_byte, 24'd0};
                    2'd1: n_blk_wd = {r_blk_rd[31:24], r_byte, 16'd0};
                    2'd2: n_blk_wd = {r_blk_rd[31:16], r_byte, 8'd0};
                    default: n_blk_wd = {r_blk_rd[31:8], r_byte};
                endcase
                n_cnt = r_cnt + 61'd1;
                n_ph = P_BYTE_WR;
            end
            P_BYTE_WR: begin
                if (w_pos == 6'd0) begin
                    n_ph = P_SCH_A; n_rnd = '0; n_idx = 4'd0;
                    w_rctl.load = 1'b1;
                end else if (r_last) begin
                    n_ph = P_PADW; n_idx = w_pos[5:2];
                end else begin
                    n_ph = P_IDLE;
                end
                n_blk_ra = w_pos[5:2];
            end
            P_PADW: begin
                // pad word r_idx; read data holds the current word for the first one
                n_blk_we = 1'b1;
                n_blk_wa = r_idx;
                if (!r_padding) begin
                    unique case (w_pos[1:0])
                        2'd0: n_blk_wd = PAD_WORD;
                        2'd1: n_blk_wd = {r_blk_rd[31:24], 24'd0} | (PAD_BYTE << 16);
                        2'd2: n_blk_wd = {r_blk_rd[31:16], 16'd0} | (PAD_BYTE << 8);
                        default: n_blk_wd = {r_blk_rd[31:8], 8'd0} | PAD_BYTE;
                    endcase
                end
                n_padding = 1'b1;
                if (r_idx == 4'd15) begin
                    // no room for the length: compress this block, pad a second one
                    if (!r_second && (w_pos >= 6'd56)) begin
                        n_second = 1'b1;
                        n_ph = P_SCH_A;
                        n_idx = 4'd0;
                        w_rctl.load = 1'b1;
                    end else begin
                        n_ph = P_LEN;
                        n_idx = 4'd14;
                    end
                    n_rnd = '0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            P_LEN: begin
                n_blk_we = 1'b1;
                n_blk_wa = r_idx;
                n_blk_wd = (r_idx == 4'd14) ? {r_cnt[60:29]} : {r_cnt[28:0], 3'd0};
                if (r_idx == 4'd15) begin
                    n_ph = P_SCH_A; n_idx = 4'd0; n_rnd = '0; n_second = 1'b0;
                    w_rctl.load = 1'b1;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            // Schedule: W[r&15] (+ sig0 W[r-15] + W[r-7] + sig1 W[r-2] for r >= 16)
            P_SCH_A: begin
                n_blk_ra = r_rnd[3:0];
                n_ph = (r_rnd < 7'd16) ? P_SCH_D : P_SCH_B;
            end
            P_SCH_B: begin
                n_acc = r_blk_rd;
                n_blk_ra = r_rnd[3:0] - 4'd15;
                n_ph = P_SCH_C;
            end
            P_SCH_C: begin
                n_acc = r_acc + sig0(r_blk_rd);
                n_blk_ra = r_rnd[3:0] - 4'd7;
                n_idx = 4'd1;
                n_ph = P_SCH_D;
            end
            P_SCH_D: begin
                if (r_rnd < 7'd16) begin
                    n_w = r_blk_rd;
                    n_ph = P_ROUND;
                end else if (r_idx == 4'd1) begin
                    n_acc = r_acc + r_blk_rd;
                    n_blk_ra = r_rnd[3:0] - 4'd2;
                    n_idx = 4'd2;
                end else begin
                    n_w = r_acc + sig1(r_blk_rd);
                    n_blk_we = 1'b1;
                    n_blk_wa = r_rnd[3:0];
                    n_blk_wd = n_w;
                    n_ph = P_ROUND;
                end
            end
            P_ROUND: begin
                w_rctl.step = 1'b1;
                n_rnd = r_rnd + 7'd1;
                n_idx = 4'd0;
                if (r_rnd == 7'd63) begin
                    n_ph = P_ADD_RD; n_idx = 4'd0;
                end else begin
                    n_ph = P_SCH_A;
                end
            end
            P_ADD_RD: begin
                n_hw_ra = r_idx[2:0];
                n_ph = P_ADD_WR;
            end
            P_ADD_WR: begin
                n_hw_we = 1'b1;
                n_hw_wa = r_idx[2:0];
                n_hw_wd = r_hw_rd + w_vars[255 - 32*r_idx[2:0] -: 32];
                if (r_idx == 4'd7) begin
                    n_idx = 4'd0; n_rnd = '0;
                    if (!r_padding) n_ph = r_last ? P_PADW : P_IDLE;
                    else if (r_second) begin
                        n_ph = P_PADW; n_idx = 4'd0;
                    end else n_ph = P_EMIT_RD;
                    if (!r_padding && r_last) n_idx = 4'd0;
                end else begin
                    n_idx = r_idx + 4'd1;
                    n_ph = P_ADD_RD;
                end
            end
            P_EMIT_RD: begin
                n_hw_ra = r_idx[2:0];
                n_ph = P_EMIT;
                n_ovalid = 1'b1;
            end
            P_EMIT: begin
                n_hw_ra = r_idx[2:0];
                if (m_axis_tready) begin
                    if (r_idx == 4'd7) begin
                        n_ovalid = 1'b0; n_ph = P_IDLE; n_cnt = '0;
                    end else begin
                        n_idx = r_idx + 4'd1; n_ph = P_EMIT_RD; n_ovalid = 1'b0;
                    end
                end
            end
            default: n_ph = P_IDLE;
        endcase
    end

    // Second block of padding: hold r_second through the zero pass from word 0
    // (r_padding set, so every word is written zero), then write the length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= P_IDLE; r_cnt <= '0; r_rnd <= '0; r_idx <= '0;
            r_padding <= 1'b0; r_second <= 1'b0; r_ovalid <= 1'b0;
            r_last <= 1'b0; r_hw_valid <= '0;
        end else begin
            r_ph <= n_ph; r_cnt <= n_cnt; r_rnd <= n_rnd; r_idx <= n_idx;
            r_padding <= n_padding; r_second <= n_second; r_ovalid <= n_ovalid;
            if (s_axis_tvalid && s_axis_tready) r_last <= s_axis_tlast;
            if (n_hw_we) r_hw_valid[n_hw_wa] <= 1'b1;
            if (r_ph == P_EMIT && m_axis_tready && r_idx == 4'd7) r_hw_valid <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_w <= n_w;
        if (s_axis_tvalid && s_axis_tready) r_byte <= s_axis_tdata;
        if (r_ph == P_EMIT_RD) begin
            r_out <= w_hval; r_oidx <= r_idx[2:0];
        end
    end

    // Output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept during emit");
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph == P_ROUND |-> r_rnd < 7'd64) else $error("round range");
endmodule

// ===== hw/rtl/sha256_round.sv =====
// One SHA-256 round per cycle while step is set, on the eight working variables.
// Depends on sha256_pkg.
module sha256_round (
    input  logic                    i_clk,
    input  sha256_pkg::t_round_ctl  i_ctl,
    input  logic [255:0]            i_hash,
    output logic [255:0]            o_vars
);
    import sha256_pkg::*;

    logic [31:0] r_v [8];
    logic [31:0] w_s0, w_s1, w_ch, w_maj, w_t1, w_t2;

    always_comb begin
        w_s1  = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1  = r_v[7] + w_s1 + w_ch + i_ctl.kw;
        w_s0  = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t2  = w_s0 + w_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= i_hash[255 - 32*i -: 32];
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_vars[255 - 32*i -: 32] = r_v[i];
    end
endmodule
